/* design/kbde_pkg.sv */
// Shared types, constants and lookup functions for the keyboard report event generator.
package kbde_pkg;

    // Number of scancode slots in one report and the index width that covers them.
    localparam int INPUT_SLOTS = 6;
    localparam int SLOT_IDX_W  = $clog2(INPUT_SLOTS);

    // Parameter defaults.
    localparam int DEF_ROLLOVER_KEYS       = 6;
    localparam int DEF_SCANCODE_TABLE_SIZE = 83;

    // Report type codes.
    localparam logic [15:0] KIND_KEYBOARD = 16'd288;
    localparam logic [15:0] KIND_EMPTY    = 16'd53312;

    // Depth of the job queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Modifier events per report and the index of the last one.
    localparam int          MOD_COUNT = 8;
    localparam logic [2:0]  MOD_LAST  = 3'd7;

    // Built-in scancode translation table.
    localparam int BUILTIN_TABLE = 83;
    localparam logic [7:0] SCAN_TABLE [BUILTIN_TABLE] = '{
        8'd0,   8'd0,   8'd0,   8'd0,
        8'd30,  8'd48,  8'd46,  8'd32,  8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,
        8'd37,  8'd38,  8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,  8'd20,
        8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,
        8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
        8'd28,  8'd1,   8'd14,  8'd15,  8'd57,  8'd12,
        8'd13,  8'd26,  8'd27,  8'd43,  8'd0,
        8'd39,  8'd40,  8'd41,  8'd51,  8'd52,  8'd53,
        8'd58,
        8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,
        8'd68,  8'd87,  8'd88,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,
        8'd106, 8'd105, 8'd108, 8'd103
    };

    // Modifier bit translation table; bit 4 has no assigned code.
    localparam logic [7:0] MOD_TABLE [MOD_COUNT] = '{
        8'd29, 8'd42, 8'd56, 8'd125, 8'd0, 8'd54, 8'd100, 8'd126
    };

    // One classified keyboard report waiting for the back end.
    typedef struct packed {
        logic [INPUT_SLOTS-1:0][7:0] rel_code;
        logic [INPUT_SLOTS-1:0]      rel_mask;
        logic [INPUT_SLOTS-1:0][7:0] press_code;
        logic [INPUT_SLOTS-1:0]      press_mask;
        logic [7:0]                  mods;
    } job_t;

    // True when a scancode has an entry in a table of the given size.
    function automatic logic in_table(input logic [7:0] sc, input int size);
        in_table = (sc != 8'd0) && (int'(sc) < size);
    endfunction

    // Translates a scancode; codes past the built-in table give zero.
    function automatic logic [7:0] translate(input logic [7:0] sc);
        if (int'(sc) < BUILTIN_TABLE) begin
            translate = SCAN_TABLE[sc[6:0]];
        end else begin
            translate = 8'd0;
        end
    endfunction

    // Index of the lowest set bit of a slot mask.
    function automatic logic [SLOT_IDX_W-1:0] lowest_set(input logic [INPUT_SLOTS-1:0] mask);
        lowest_set = '0;
        for (int i = INPUT_SLOTS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                lowest_set = SLOT_IDX_W'(i);
            end
        end
    endfunction

endpackage

/* design/keyboard_report_to_key_events.sv */
// Top level of the keyboard report to key event converter.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    packet_kind, key_slot0..5, modifier_bits
//   m_       out        m_valid/m_ready    key_code, is_press, final_event
//
// The front end takes one report per cycle while the two-entry job queue has room;
// reports that are not keyboard reports are dropped there in that cycle.
// A keyboard report gives 8 to 20 events, one per cycle from the back end while m_ready does
// not stall it, after the job is loaded; the next job loads once the last event is registered.
// Reset is synchronous and active low; it clears the remembered keys and the queue.
// A stall on m_ready holds the output register; the queue then fills and drops s_ready.
module keyboard_report_to_key_events #(
    parameter int ROLLOVER_KEYS       = kbde_pkg::DEF_ROLLOVER_KEYS,
    parameter int SCANCODE_TABLE_SIZE = kbde_pkg::DEF_SCANCODE_TABLE_SIZE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_packet_kind,
    input  logic [7:0]  s_key_slot0,
    input  logic [7:0]  s_key_slot1,
    input  logic [7:0]  s_key_slot2,
    input  logic [7:0]  s_key_slot3,
    input  logic [7:0]  s_key_slot4,
    input  logic [7:0]  s_key_slot5,
    input  logic [7:0]  s_modifier_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_key_code,
    output logic        m_is_press,
    output logic        m_final_event
);

    logic           push;
    kbde_pkg::job_t push_job;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    kbde_pkg::job_t q_job;

    kbde_front #(
        .ROLLOVER_KEYS       (ROLLOVER_KEYS),
        .SCANCODE_TABLE_SIZE (SCANCODE_TABLE_SIZE)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_packet_kind   (s_packet_kind),
        .s_key_slot0     (s_key_slot0),
        .s_key_slot1     (s_key_slot1),
        .s_key_slot2     (s_key_slot2),
        .s_key_slot3     (s_key_slot3),
        .s_key_slot4     (s_key_slot4),
        .s_key_slot5     (s_key_slot5),
        .s_modifier_bits (s_modifier_bits),
        .push            (push),
        .push_job        (push_job),
        .q_full          (q_full)
    );

    kbde_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    kbde_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_job         (q_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_code    (m_key_code),
        .m_is_press    (m_is_press),
        .m_final_event (m_final_event)
    );

endmodule

/* design/kbde_front.sv */
// Front end: accepts reports, compares against the remembered keys and builds event jobs.
module kbde_front #(
    parameter int ROLLOVER_KEYS       = kbde_pkg::DEF_ROLLOVER_KEYS,
    parameter int SCANCODE_TABLE_SIZE = kbde_pkg::DEF_SCANCODE_TABLE_SIZE
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [15:0]   s_packet_kind,
    input  logic [7:0]    s_key_slot0,
    input  logic [7:0]    s_key_slot1,
    input  logic [7:0]    s_key_slot2,
    input  logic [7:0]    s_key_slot3,
    input  logic [7:0]    s_key_slot4,
    input  logic [7:0]    s_key_slot5,
    input  logic [7:0]    s_modifier_bits,
    output logic          push,
    output kbde_pkg::job_t push_job,
    input  logic          q_full
);

    localparam int SLOTS_USED = (ROLLOVER_KEYS < kbde_pkg::INPUT_SLOTS) ?
                                ROLLOVER_KEYS : kbde_pkg::INPUT_SLOTS;

    logic [SLOTS_USED-1:0][7:0]              prev_keys_reg;
    logic [SLOTS_USED-1:0][7:0]              prev_keys_next;
    logic [kbde_pkg::INPUT_SLOTS-1:0][7:0]   fresh;
    logic                                    accept;
    logic                                    is_keyboard;
    logic                                    held;

    assign s_ready     = !q_full;
    assign accept      = s_valid && s_ready;
    assign is_keyboard = (s_packet_kind == kbde_pkg::KIND_KEYBOARD);
    assign push        = accept && is_keyboard;

    assign fresh[0] = s_key_slot0;
    assign fresh[1] = s_key_slot1;
    assign fresh[2] = s_key_slot2;
    assign fresh[3] = s_key_slot3;
    assign fresh[4] = s_key_slot4;
    assign fresh[5] = s_key_slot5;

    // Classify releases and presses for every active slot.
    always_comb begin
        push_job       = '0;
        push_job.mods  = s_modifier_bits;
        prev_keys_next = prev_keys_reg;
        held           = 1'b0;
        for (int i = 0; i < SLOTS_USED; i++) begin
            held = 1'b0;
            for (int j = 0; j < SLOTS_USED; j++) begin
                if (fresh[j] == prev_keys_reg[i]) begin
                    held = 1'b1;
                end
            end
            push_job.rel_mask[i]   = !held &&
                                     kbde_pkg::in_table(prev_keys_reg[i], SCANCODE_TABLE_SIZE);
            push_job.rel_code[i]   = kbde_pkg::translate(prev_keys_reg[i]);
            push_job.press_mask[i] = kbde_pkg::in_table(fresh[i], SCANCODE_TABLE_SIZE);
            push_job.press_code[i] = kbde_pkg::translate(fresh[i]);
            prev_keys_next[i]      = fresh[i];
        end
    end

    // Remembered keys change only on an accepted keyboard report.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_keys_reg <= '0;
        end else if (push) begin
            prev_keys_reg <= prev_keys_next;
        end
    end

endmodule

/* design/kbde_queue.sv */
// Short job queue that decouples the front end from the back end.
module kbde_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  kbde_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output kbde_pkg::job_t q_job
);

    localparam int PTR_W = (kbde_pkg::QUEUE_DEPTH > 1) ? $clog2(kbde_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(kbde_pkg::QUEUE_DEPTH + 1);

    kbde_pkg::job_t   entries_reg [kbde_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(kbde_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Pointer wrap at the queue depth.
    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(kbde_pkg::QUEUE_DEPTH - 1)) begin
            bump = '0;
        end else begin
            bump = p + PTR_W'(1);
        end
    endfunction

    // Entry storage holds payload only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* design/kbde_back.sv */
// Back end: walks one job and emits its events, one per cycle unless m_ready stalls, through an output register.
module kbde_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  kbde_pkg::job_t q_job,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_key_code,
    output logic           m_is_press,
    output logic           m_final_event
);

    localparam logic [kbde_pkg::INPUT_SLOTS-1:0] SLOT_ONE =
        {{(kbde_pkg::INPUT_SLOTS-1){1'b0}}, 1'b1};

    logic                                  busy_reg, busy_next;
    logic [kbde_pkg::INPUT_SLOTS-1:0][7:0] rel_code_reg;
    logic [kbde_pkg::INPUT_SLOTS-1:0][7:0] press_code_reg;
    logic [kbde_pkg::INPUT_SLOTS-1:0]      rel_mask_reg, rel_mask_next;
    logic [kbde_pkg::INPUT_SLOTS-1:0]      press_mask_reg, press_mask_next;
    logic [7:0]                            mods_reg;
    logic [2:0]                            mod_cnt_reg, mod_cnt_next;
    logic                                  m_valid_reg, m_valid_next;
    logic [7:0]                            code_reg;
    logic                                  press_reg;
    logic                                  final_reg;
    logic [kbde_pkg::SLOT_IDX_W-1:0]       rel_idx;
    logic [kbde_pkg::SLOT_IDX_W-1:0]       press_idx;
    logic                                  advance;
    logic [7:0]                            ev_code;
    logic                                  ev_press;
    logic                                  ev_final;

    assign pop     = !busy_reg && q_valid;
    assign advance = busy_reg && (!m_valid_reg || m_ready);

    assign rel_idx   = kbde_pkg::lowest_set(rel_mask_reg);
    assign press_idx = kbde_pkg::lowest_set(press_mask_reg);

    // Pick the current event: releases first, then presses, then the modifier sweep.
    always_comb begin
        rel_mask_next   = rel_mask_reg;
        press_mask_next = press_mask_reg;
        mod_cnt_next    = mod_cnt_reg;
        busy_next       = busy_reg;
        ev_final        = 1'b0;
        if (|rel_mask_reg) begin
            ev_code  = rel_code_reg[rel_idx];
            ev_press = 1'b0;
            rel_mask_next = rel_mask_reg & (rel_mask_reg - SLOT_ONE);
        end else if (|press_mask_reg) begin
            ev_code  = press_code_reg[press_idx];
            ev_press = 1'b1;
            press_mask_next = press_mask_reg & (press_mask_reg - SLOT_ONE);
        end else begin
            ev_code      = kbde_pkg::MOD_TABLE[mod_cnt_reg];
            ev_press     = mods_reg[mod_cnt_reg];
            ev_final     = (mod_cnt_reg == kbde_pkg::MOD_LAST);
            mod_cnt_next = mod_cnt_reg + 3'd1;
        end
        if (ev_final) begin
            busy_next = 1'b0;
        end
        if (!advance) begin
            rel_mask_next   = rel_mask_reg;
            press_mask_next = press_mask_reg;
            mod_cnt_next    = mod_cnt_reg;
            busy_next       = busy_reg;
        end
        if (pop) begin
            busy_next       = 1'b1;
            rel_mask_next   = q_job.rel_mask;
            press_mask_next = q_job.press_mask;
            mod_cnt_next    = '0;
        end
    end

    // Output register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            rel_mask_reg   <= '0;
            press_mask_reg <= '0;
            mod_cnt_reg    <= '0;
        end else begin
            busy_reg       <= busy_next;
            m_valid_reg    <= m_valid_next;
            rel_mask_reg   <= rel_mask_next;
            press_mask_reg <= press_mask_next;
            mod_cnt_reg    <= mod_cnt_next;
        end
    end

    // Job payload and output payload.
    always_ff @(posedge aclk) begin
        if (pop) begin
            rel_code_reg   <= q_job.rel_code;
            press_code_reg <= q_job.press_code;
            mods_reg       <= q_job.mods;
        end
        if (advance) begin
            code_reg  <= ev_code;
            press_reg <= ev_press;
            final_reg <= ev_final;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_key_code    = code_reg;
    assign m_is_press    = press_reg;
    assign m_final_event = final_reg;

endmodule

/* design/kbde_checker.sv */
// Port-level checker for the key event converter and its bind statement.
module kbde_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_key_code,
    input logic       m_is_press,
    input logic       m_final_event
);

    // A stalled result transaction keeps its valid and payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_key_code) && $stable(m_is_press)
                                && $stable(m_final_event))
        else $error("stalled result transaction changed");

    // Reset leaves no result pending and the input side open.
    assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the channels");

    // The last event of a report is always the top modifier bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_final_event |-> m_key_code == kbde_pkg::MOD_TABLE[kbde_pkg::MOD_LAST])
        else $error("final event is not the last modifier");

    // After a stall-free handoff of a final event, the next event is never that final key turned from press to release.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_final_event |=> !(m_valid && m_final_event &&
            $past(m_key_code) == m_key_code && !m_is_press && $past(m_is_press)))
        else $error("final event changed press state in place");

endmodule

bind keyboard_report_to_key_events kbde_checker u_kbde_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_key_code    (m_key_code),
    .m_is_press    (m_is_press),
    .m_final_event (m_final_event)
);
